FILE: rtl/dhe_pkg.sv
// Package for the Diffie-Hellman exchange block: default sizes and the
// shared-unit operation codes. No dependencies.
package dhe_pkg;
  localparam int unsigned QBitsDefault   = 16;
  localparam int unsigned MaxFacDefault  = 6;

  typedef enum logic [1:0] {
    OP_MOD  = 2'd0,  // a % m
    OP_DIV  = 2'd1,  // a / m
    OP_MUL  = 2'd2   // (a * b) % m
  } dhe_op_t;
endpackage

FILE: rtl/dhe_alu.sv
// Shared iterative unit: restoring divide for mod/div, and shift-add
// modular multiply, one bit per cycle. Uses dhe_pkg.
module dhe_alu import dhe_pkg::*; #(
  parameter int unsigned QBits = QBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dhe_op_t          op,
  input  logic [QBits-1:0] a,
  input  logic [QBits-1:0] b,
  input  logic [QBits-1:0] m,
  output logic             done,
  output logic [QBits-1:0] res
);
  localparam int unsigned CW = $clog2(QBits + 1);

  typedef enum logic [1:0] { S_IDLE, S_RUN, S_DONE } st_t;

  st_t              st;
  dhe_op_t          opr;
  logic [QBits-1:0] sh;       // dividend shift or multiplier bits
  logic [QBits-1:0] mb;       // multiplicand
  logic [QBits-1:0] mm;
  logic [QBits:0]   rem;
  logic [QBits-1:0] quo;
  logic [CW-1:0]    cnt;

  logic [QBits+1:0] dbl, dsub, radd, rsub;
  logic [QBits:0]   rsh, rsub0;

  always_comb begin
    // divide step
    rsh   = {rem[QBits-1:0], sh[QBits-1]};
    rsub0 = rsh - {1'b0, mm};
    // multiply step (Horner, msb first): r = 2r mod m, then + b mod m
    dbl   = {1'b0, rem} << 1;
    dsub  = (dbl >= {2'b0, mm}) ? dbl - {2'b0, mm} : dbl;
    radd  = dsub + (sh[QBits-1] ? {2'b0, mb} : '0);
    rsub  = (radd >= {2'b0, mm}) ? radd - {2'b0, mm} : radd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: if (start) begin
          opr <= op;
          mm  <= m;
          cnt <= CW'(QBits);
          rem <= '0;
          quo <= '0;
          if (op == OP_MUL) begin
            sh <= a;
            mb <= (b >= m) ? b - m : b;  // b reduced by one conditional subtract of m
          end else begin
            sh <= a;
            mb <= '0;
          end
          st <= S_RUN;
        end
        S_RUN: begin
          if (opr == OP_MUL) begin
            rem <= rsub[QBits:0];
          end else if (!rsub0[QBits]) begin
            rem <= rsub0;
            quo <= {quo[QBits-2:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[QBits-2:0], 1'b0};
          end
          sh  <= sh << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= S_DONE;
        end
        S_DONE: begin
          res  <= (opr == OP_DIV) ? quo : rem[QBits-1:0];
          done <= 1'b1;
          st   <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/diffie_hellman_exchange_top.sv
// Top level of the Diffie-Hellman exchange block: sequencer around the
// shared divide/multiply unit. Uses dhe_pkg and dhe_alu.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | q_modulus, private_key_a, private_key_b
//  out     | output    | out_valid/out_stall | status, generator, public_a/b, shared_key
//
// Every arithmetic step (mod, div, modular multiply) runs on the one shared
// unit. An item's cost is set by trial division, the root search and the
// exponentiations; a bad key or a modulus below two is rejected at the
// check, before any of them.
// One item at a time: in_stall is high from acceptance until the result
// register empties. Reset is synchronous and clears the sequencer and out_valid.
module diffie_hellman_exchange_top import dhe_pkg::*; #(
  parameter int unsigned QBits  = QBitsDefault,
  parameter int unsigned MaxFac = MaxFacDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [QBits-1:0] q_modulus,
  input  logic [QBits-1:0] private_key_a,
  input  logic [QBits-1:0] private_key_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             status,
  output logic [QBits-1:0] generator,
  output logic [QBits-1:0] public_a,
  output logic [QBits-1:0] public_b,
  output logic [QBits-1:0] shared_key
);
  localparam int unsigned FW = (MaxFac > 1) ? $clog2(MaxFac) : 1;
  localparam int unsigned NW = $clog2(MaxFac + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_PT_D, S_PT_SQ, S_PT_CMP, S_PT_MOD,
    S_FC_SQ, S_FC_CMP, S_FC_MOD, S_FC_DIV,
    S_RT_G, S_RT_EXP, S_RT_TEST,
    S_EX_SET, S_PW_STEP, S_PW_SQ, S_PW_END, S_OUT
  } st_t;

  st_t              st;
  st_t              ret;       // where to go after an exponentiation
  logic [QBits-1:0] q, xa, xb;
  logic [QBits-1:0] d;         // trial divisor
  logic             d_ovf;     // trial divisor ran past the word
  logic [QBits-1:0] n;         // remaining cofactor of q-1
  logic [QBits-1:0] fac [MaxFac];
  logic [NW-1:0]    fcnt;
  logic [NW-1:0]    k;
  logic [QBits-1:0] g;
  logic [QBits-1:0] acc, base, ex;
  logic [1:0]       pw_ph;     // power phase sub-step
  logic [1:0]       which;     // 0 ya, 1 yb, 2 key
  logic [QBits-1:0] ya, yb;
  logic             sq_hi;     // d*d above the bound (q or n), or search done

  logic             alu_start, alu_done;
  dhe_op_t          alu_op;
  logic [QBits-1:0] alu_a, alu_b, alu_m, alu_res;
  logic [2*QBits-1:0] dsq;

  dhe_alu #(.QBits(QBits)) u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(alu_op),
    .a(alu_a), .b(alu_b), .m(alu_m), .done(alu_done), .res(alu_res)
  );

  assign in_stall = (st != S_IDLE);
  assign dsq = (2*QBits)'(d) * (2*QBits)'(d);   // full-width square, one multiplier

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      alu_start <= 1'b0;
    end else begin
      alu_start <= 1'b0;
      unique case (st)
        S_IDLE: if (in_valid) begin
          q  <= q_modulus;
          xa <= private_key_a;
          xb <= private_key_b;
          st <= S_CHK;
        end
        S_CHK: begin
          if (q <= QBits'(1) || xa >= q || xb >= q) begin
            status <= 1'b1; generator <= '0; public_a <= '0;
            public_b <= '0; shared_key <= '0;
            out_valid <= 1'b1; st <= S_OUT;
          end else if (q == QBits'(2)) begin
            status <= 1'b0; generator <= QBits'(1); public_a <= QBits'(1);
            public_b <= QBits'(1); shared_key <= QBits'(1);
            out_valid <= 1'b1; st <= S_OUT;
          end else begin
            d <= QBits'(2); d_ovf <= 1'b0; st <= S_PT_SQ;
          end
        end
        // primality by trial division over every d with d*d <= q
        S_PT_SQ: begin
          sq_hi <= d_ovf || (dsq[2*QBits-1:QBits] != '0) || (dsq[QBits-1:0] > q);
          st <= S_PT_CMP;
        end
        S_PT_CMP: begin
          if (sq_hi) begin
            n <= q - 1'b1; fcnt <= '0; d <= QBits'(2); d_ovf <= 1'b0;
            st <= S_FC_SQ;
          end else begin
            alu_op <= OP_MOD; alu_a <= q; alu_m <= d; alu_b <= '0;
            alu_start <= 1'b1; st <= S_PT_MOD;
          end
        end
        S_PT_MOD: if (alu_done) begin
          if (alu_res == '0) begin
            status <= 1'b1; generator <= '0; public_a <= '0;
            public_b <= '0; shared_key <= '0;
            out_valid <= 1'b1; st <= S_OUT;
          end else begin
            {d_ovf, d} <= {1'b0, d} + 1'b1;
            st <= S_PT_SQ;
          end
        end
        // prime factors of q-1, up to MaxFac; the last may repeat
        S_FC_SQ: begin
          sq_hi <= d_ovf || (n <= QBits'(1)) ||
                   (dsq[2*QBits-1:QBits] != '0) || (dsq[QBits-1:0] > n);
          st <= S_FC_CMP;
        end
        S_FC_CMP: begin
          if (sq_hi) begin
            if (n > QBits'(1) && fcnt < NW'(MaxFac)) begin
              fac[fcnt[FW-1:0]] <= n; fcnt <= fcnt + 1'b1;
            end
            g <= QBits'(2); st <= S_RT_G;
          end else begin
            alu_op <= OP_MOD; alu_a <= n; alu_m <= d; alu_b <= '0;
            alu_start <= 1'b1; st <= S_FC_MOD;
          end
        end
        S_FC_MOD: if (alu_done) begin
          if (alu_res == '0) begin
            if ((fcnt == '0 || fac[fcnt[FW-1:0] - 1'b1] != d) &&
                fcnt < NW'(MaxFac)) begin
              fac[fcnt[FW-1:0]] <= d; fcnt <= fcnt + 1'b1;
            end
            alu_op <= OP_DIV; alu_a <= n; alu_m <= d;
            alu_start <= 1'b1; st <= S_FC_DIV;
          end else begin
            {d_ovf, d} <= {1'b0, d} + 1'b1;
            st <= S_FC_SQ;
          end
        end
        S_FC_DIV: if (alu_done) begin
          n <= alu_res; st <= S_FC_SQ;
        end
        // root search: g passes when g^((q-1)/f) != 1 for every factor
        S_RT_G: begin
          if (g >= q) begin
            status <= 1'b1; generator <= '0; public_a <= '0;
            public_b <= '0; shared_key <= '0;
            out_valid <= 1'b1; st <= S_OUT;
          end else begin
            k <= '0; st <= S_RT_EXP;
          end
        end
        S_RT_EXP: begin
          if (k >= fcnt) begin
            which <= 2'd0; st <= S_EX_SET;
          end else begin
            alu_op <= OP_DIV; alu_a <= q - 1'b1; alu_m <= fac[k[FW-1:0]];
            alu_start <= 1'b1; st <= S_RT_TEST; pw_ph <= 2'd0;
          end
        end
        S_RT_TEST: if (alu_done) begin
          // quotient ready: run g^quot
          acc <= QBits'(1); base <= g; ex <= alu_res; ret <= S_RT_TEST;
          st <= S_PW_STEP;
        end
        // exponentiations for the results
        S_EX_SET: begin
          acc <= QBits'(1); ret <= S_EX_SET;
          unique case (which)
            2'd0: begin base <= g;  ex <= xa; end
            2'd1: begin base <= g;  ex <= xb; end
            default: begin base <= yb; ex <= xa; end
          endcase
          st <= S_PW_STEP;
        end
        // square and multiply on the shared unit
        S_PW_STEP: begin
          if (ex == '0) begin
            st <= S_PW_END;
          end else if (ex[0]) begin
            alu_op <= OP_MUL; alu_a <= acc; alu_b <= base; alu_m <= q;
            alu_start <= 1'b1; pw_ph <= 2'd1; st <= S_PW_SQ;
          end else begin
            alu_op <= OP_MUL; alu_a <= base; alu_b <= base; alu_m <= q;
            alu_start <= 1'b1; pw_ph <= 2'd2; st <= S_PW_SQ;
          end
        end
        S_PW_SQ: if (alu_done) begin
          if (pw_ph == 2'd1) begin
            acc <= alu_res;
            alu_op <= OP_MUL; alu_a <= base; alu_b <= base; alu_m <= q;
            alu_start <= 1'b1; pw_ph <= 2'd2;
          end else begin
            base <= alu_res; ex <= ex >> 1; st <= S_PW_STEP;
          end
        end
        S_PW_END: begin
          if (ret == S_RT_TEST) begin
            if (acc == QBits'(1)) begin
              g <= g + 1'b1; st <= S_RT_G;
            end else begin
              k <= k + 1'b1; st <= S_RT_EXP;
            end
          end else begin
            unique case (which)
              2'd0: begin ya <= acc; which <= 2'd1; st <= S_EX_SET; end
              2'd1: begin yb <= acc; which <= 2'd2; st <= S_EX_SET; end
              default: begin
                status <= 1'b0; generator <= g; public_a <= ya;
                public_b <= yb; shared_key <= acc;
                out_valid <= 1'b1; st <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/dhe_checker.sv
// Port-level checker for the Diffie-Hellman exchange block, bound to the
// top level. Uses dhe_pkg defaults.
module dhe_checker import dhe_pkg::*; #(
  parameter int unsigned QBits = QBitsDefault
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             status,
  input logic [QBits-1:0] generator,
  input logic [QBits-1:0] shared_key
);
  // a result means an item is in hand, so no new item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_valid) |-> in_stall) else $error("item accepted while result held");

  // failed items carry a zero generator and shared key
  a_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (generator == '0 && shared_key == '0))
    else $error("failure result not zeroed");

  // success always reports a nonzero generator
  a_gen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> (generator != '0))
    else $error("success with zero generator");

  // held result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(generator)))
    else $error("stalled result changed");
endmodule

bind diffie_hellman_exchange_top dhe_checker #(.QBits(QBits)) u_dhe_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .generator(generator), .shared_key(shared_key)
);
